// ----- rtl/lls_pkg.sv -----
// Shared types and codes for the linked-list stack with free list.
// No dependencies; used by every file under rtl but lls_ram.
package lls_pkg;

  localparam int SLOTS_DEF      = 32;
  localparam int DATA_WIDTH_DEF = 8;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_LIST   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_ELEM  = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] value;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] element;
    logic       last;
  } out_rsp_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

// ----- rtl/lls_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/linked_list_stack_with_free_list_core.sv -----
// Top level of the linked-list stack with free list.
// Depends on lls_pkg and lls_ram (link memory and data memory).
//
// Usage: a request (op, value) is taken at a clock edge where start is high
// and busy is low. Results come out on out_rsp, one per cycle in which
// out_valid is high; the receiver cannot stall them. The final result of a
// request carries last.
// Insert and delete: one link memory read, then the read-modify-write of the
// link in S_EXEC, with the result registered from there; busy is high for one cycle.
// List: a first read, then one element per cycle as the walk follows
// the links read back from the link memory. Op code 3 gives no result
// and leaves busy low.
// The request after one that finishes can be taken in the cycle its last
// result is shown; insert and delete requests are taken one at a time.
// Reset: list empty, all slots free, chained in slot order. The untouched
// part of the free chain is kept implicit by a fill mark, so no clearing
// pass is needed and the block is ready right after reset.
module linked_list_stack_with_free_list_core
  import lls_pkg::*;
#(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_valid,
  output out_rsp_t out_rsp
);

  localparam int LW = $clog2(SLOTS + 1);
  localparam int AW = $clog2(SLOTS);
  localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);
  localparam logic [LW-1:0] LAST_CNT  = LW'(SLOTS - 1);

  state_t          state_r, state_nxt;
  logic [LW-1:0]   list_head_r, list_head_nxt;
  logic [LW-1:0]   free_head_r, free_head_nxt;
  logic [LW-1:0]   fill_r, fill_nxt;
  logic [LW-1:0]   cur_r, cur_nxt;
  logic [LW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]      op_r, op_nxt;
  logic [7:0]      value_r, value_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_rsp_t        out_rsp_r, out_rsp_nxt;

  logic                  link_we;
  logic [LW-1:0]         link_wdata;
  logic [LW-1:0]         link_rdata;
  logic                  byte_we;
  logic [DATA_WIDTH-1:0] byte_rdata;
  logic [AW-1:0]         raddr;
  logic [LW-1:0]         link_eff;
  logic [LW-1:0]         nx;
  logic                  fin;
  logic                  accept;

  lls_ram #(.WIDTH(LW), .DEPTH(SLOTS)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (cur_r[AW-1:0]),
    .wdata (link_wdata),
    .raddr (raddr),
    .rdata (link_rdata)
  );

  lls_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_byte_ram (
    .clk   (clk),
    .we    (byte_we),
    .waddr (cur_r[AW-1:0]),
    .wdata (DATA_WIDTH'(value_r)),
    .raddr (raddr),
    .rdata (byte_rdata)
  );

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // slots at or above the fill mark were never written: reset chain
  assign link_eff = (cur_r < fill_r) ? link_rdata : cur_r + LW'(1);
  assign nx       = (link_eff < NULL_LINK) ? link_eff : NULL_LINK;
  assign fin      = (nx == NULL_LINK) || (cnt_r == LAST_CNT);

  always_comb begin
    state_nxt     = state_r;
    list_head_nxt = list_head_r;
    free_head_nxt = free_head_r;
    fill_nxt      = fill_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    op_nxt        = op_r;
    value_nxt     = value_r;
    out_valid_nxt = 1'b0;
    out_rsp_nxt   = '0;
    link_we       = 1'b0;
    link_wdata    = list_head_r;
    byte_we       = 1'b0;
    raddr         = nx[AW-1:0];
    case (state_r)
      S_IDLE: begin
        cur_nxt = (in_req.op == OP_INSERT) ? free_head_r : list_head_r;
        raddr   = cur_nxt[AW-1:0];
        if (accept && in_req.op != OP_NONE) begin
          op_nxt    = in_req.op;
          value_nxt = in_req.value;
          cnt_nxt   = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt    = 1'b1;
        out_rsp_nxt.last = 1'b1;
        state_nxt        = S_IDLE;
        if (cur_r == NULL_LINK) begin
          out_rsp_nxt.status = (op_r == OP_INSERT) ? ST_FULL : ST_EMPTY;
        end else begin
          case (op_r)
            OP_INSERT: begin
              link_we            = 1'b1;
              link_wdata         = list_head_r;
              byte_we            = 1'b1;
              free_head_nxt      = nx;
              list_head_nxt      = cur_r;
              if (cur_r == fill_r) begin
                fill_nxt = fill_r + LW'(1);
              end
              out_rsp_nxt.status = ST_DONE;
            end
            OP_DELETE: begin
              link_we            = 1'b1;
              link_wdata         = free_head_r;
              list_head_nxt      = nx;
              free_head_nxt      = cur_r;
              out_rsp_nxt.status = ST_DONE;
            end
            default: begin
              out_rsp_nxt.status  = ST_ELEM;
              out_rsp_nxt.element = 8'(byte_rdata);
              out_rsp_nxt.last    = fin;
              if (!fin) begin
                cur_nxt   = nx;
                cnt_nxt   = cnt_r + LW'(1);
                state_nxt = S_EXEC;
              end
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      list_head_r <= NULL_LINK;
      free_head_r <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      list_head_r <= list_head_nxt;
      free_head_r <= free_head_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r     <= cur_nxt;
    cnt_r     <= cnt_nxt;
    op_r      <= op_nxt;
    value_r   <= value_nxt;
    out_rsp_r <= out_rsp_nxt;
  end

endmodule

// ----- rtl/lls_checker.sv -----
// Port-level checks for the linked-list stack core, bound to the top level.
// Depends on lls_pkg and linked_list_stack_with_free_list_core.
module lls_checker
  import lls_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input in_req_t  in_req,
  input logic     out_valid,
  input out_rsp_t out_rsp
);

  // insert and delete answer with a single final result
  a_single_rsp: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req.op == OP_INSERT || in_req.op == OP_DELETE)
    |-> ##2 (out_valid && out_rsp.last))
    else $error("insert/delete result missing");

  a_nop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_req.op == OP_NONE |=> !busy && !out_valid)
    else $error("unused op started work");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != ST_ELEM |-> out_rsp.last && out_rsp.element == 8'd0)
    else $error("non-element result not final or not zero");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.last |-> !busy)
    else $error("busy after final result");

  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.last |-> busy)
    else $error("list walk stopped early");

endmodule

bind linked_list_stack_with_free_list_core lls_checker u_lls_checker (.*);

// ----- bench/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking bench for linked_list_stack_with_free_list_core: a directed
// table, then random insert/delete/list traffic, checked against a slot-store predictor.
// Depends on lls_pkg and the RTL under rtl.
module tb_top;
  import lls_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int LW = $clog2(SLOTS + 1);
  localparam int RAND_ITEMS = 140;
  localparam int CYCLE_LIMIT = 200000;

  typedef logic [LW-1:0] link_t;
  localparam link_t NIL = link_t'(SLOTS);

  typedef struct {
    logic [1:0] op;
    logic [7:0] value;
    int         reps;
    bit         typed;
    logic [1:0] st;
  } row_t;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  in_req_t  in_req;
  logic     out_valid;
  out_rsp_t out_rsp;

  bit       hint_on;
  out_rsp_t hint_rsp;

  link_t      nxt_mem [SLOTS];
  logic [7:0] dat_mem [SLOTS];
  link_t      list_hd;
  link_t      free_hd;

  out_rsp_t step_q [$];
  out_rsp_t rsp_due_q [$];
  row_t     dir_rows [$];
  int       err_cnt = 0;
  int       cyc = 0;

  linked_list_stack_with_free_list_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic out_rsp_t mk_rsp(input logic [1:0] st, input logic [7:0] el,
                                      input logic lst);
    out_rsp_t r;
    r.status  = st;
    r.element = el;
    r.last    = lst;
    return r;
  endfunction

  function automatic link_t norm_link(input link_t v);
    return (v < SLOTS) ? v : NIL;
  endfunction

  task automatic clear_list_state();
    for (int i = 0; i < SLOTS; i++) begin
      nxt_mem[i] = (i + 1 < SLOTS) ? link_t'(i + 1) : NIL;
      dat_mem[i] = 8'h00;
    end
    list_hd = NIL;
    free_hd = '0;
  endtask

  // Updates the shadow list and leaves the responses of one request in step_q.
  task automatic compute_list_rsp(input in_req_t req);
    link_t s;
    link_t nx;
    int    n;
    step_q.delete();
    case (req.op)
      OP_INSERT: begin
        s = norm_link(free_hd);
        if (s == NIL) begin
          step_q.push_back(mk_rsp(ST_FULL, 8'h00, 1'b1));
        end else begin
          free_hd = norm_link(nxt_mem[s]);
          dat_mem[s] = req.value;
          nxt_mem[s] = norm_link(list_hd);
          list_hd = s;
          step_q.push_back(mk_rsp(ST_DONE, 8'h00, 1'b1));
        end
      end
      OP_DELETE: begin
        s = norm_link(list_hd);
        if (s == NIL) begin
          step_q.push_back(mk_rsp(ST_EMPTY, 8'h00, 1'b1));
        end else begin
          list_hd = norm_link(nxt_mem[s]);
          nxt_mem[s] = norm_link(free_hd);
          free_hd = s;
          step_q.push_back(mk_rsp(ST_DONE, 8'h00, 1'b1));
        end
      end
      OP_LIST: begin
        s = norm_link(list_hd);
        n = 0;
        if (s == NIL) begin
          step_q.push_back(mk_rsp(ST_EMPTY, 8'h00, 1'b1));
        end else begin
          while (s != NIL && n < SLOTS) begin
            nx = norm_link(nxt_mem[s]);
            step_q.push_back(mk_rsp(ST_ELEM, dat_mem[s], (nx == NIL) || (n + 1 >= SLOTS)));
            n++;
            s = nx;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    err_cnt++;
    if (err_cnt <= 40)
      $display("MISMATCH %s: got %0h expected %0h (cycle %0d)", what, got, want, cyc);
  endtask

  always @(posedge clk) begin
    out_rsp_t want;
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (rsp_due_q.size() == 0) begin
          report_mismatch("result with none expected", out_rsp.element, 8'h00);
        end else begin
          want = rsp_due_q.pop_front();
          if (out_rsp.status !== want.status)
            report_mismatch("status", 8'(out_rsp.status), 8'(want.status));
          if (out_rsp.element !== want.element)
            report_mismatch("element", out_rsp.element, want.element);
          if (out_rsp.last !== want.last)
            report_mismatch("last", 8'(out_rsp.last), 8'(want.last));
        end
      end
      if (start && busy === 1'b0) begin
        compute_list_rsp(in_req);
        if (hint_on)
          rsp_due_q.push_back(hint_rsp);
        else
          foreach (step_q[i]) rsp_due_q.push_back(step_q[i]);
      end
    end
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance and any gap.
  task automatic issue(input in_req_t req, input bit typed, input out_rsp_t trsp,
                       input int gap);
    in_req   <= req;
    hint_on  <= typed;
    hint_rsp <= trsp;
    start    <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    @(negedge clk);
    if (gap > 0) begin
      start   <= 1'b0;
      hint_on <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic add_row(input logic [1:0] op, input logic [7:0] value, input int reps,
                         input bit typed, input logic [1:0] st);
    row_t row;
    row.op    = op;
    row.value = value;
    row.reps  = reps;
    row.typed = typed;
    row.st    = st;
    dir_rows.push_back(row);
  endtask

  initial begin
    in_req_t req;
    int      k;
    int      r;
    int      sent;
    int      next_phase;
    int      next_drain;
    int      ins_pct;
    bit      quiet;

    rst_n    = 1'b0;
    start    = 1'b0;
    in_req   = '0;
    hint_on  = 1'b0;
    hint_rsp = '0;
    clear_list_state();

    add_row(OP_DELETE, 8'h00, 1,     1'b1, ST_EMPTY);
    add_row(OP_LIST,   8'h00, 1,     1'b1, ST_EMPTY);
    add_row(OP_NONE,   8'h5A, 1,     1'b0, ST_DONE);
    add_row(OP_INSERT, 8'h00, 1,     1'b1, ST_DONE);
    add_row(OP_INSERT, 8'hFF, 1,     1'b1, ST_DONE);
    add_row(OP_LIST,   8'h00, 1,     1'b0, ST_DONE);
    add_row(OP_DELETE, 8'h00, 1,     1'b1, ST_DONE);
    add_row(OP_DELETE, 8'hFF, 1,     1'b1, ST_DONE);
    add_row(OP_DELETE, 8'h00, 1,     1'b1, ST_EMPTY);
    add_row(OP_INSERT, 8'h01, SLOTS, 1'b1, ST_DONE);
    add_row(OP_INSERT, 8'hFF, 1,     1'b1, ST_FULL);
    add_row(OP_LIST,   8'h00, 1,     1'b0, ST_DONE);
    add_row(OP_NONE,   8'hFF, 1,     1'b0, ST_DONE);
    add_row(OP_DELETE, 8'h00, SLOTS, 1'b1, ST_DONE);
    add_row(OP_DELETE, 8'h00, 1,     1'b1, ST_EMPTY);
    add_row(OP_INSERT, 8'h80, 3,     1'b1, ST_DONE);
    add_row(OP_DELETE, 8'h00, 1,     1'b1, ST_DONE);
    add_row(OP_INSERT, 8'h7F, 1,     1'b1, ST_DONE);
    add_row(OP_LIST,   8'h00, 1,     1'b0, ST_DONE);
    add_row(OP_DELETE, 8'h00, 3,     1'b1, ST_DONE);
    add_row(OP_LIST,   8'h00, 1,     1'b1, ST_EMPTY);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      for (k = 0; k < dir_rows[i].reps; k++) begin
        req.op    = dir_rows[i].op;
        req.value = dir_rows[i].value + 8'(k);
        issue(req, dir_rows[i].typed, mk_rsp(dir_rows[i].st, 8'h00, 1'b1), rand_gap());
      end
    end

    sent       = 0;
    next_phase = 0;
    next_drain = 70;
    ins_pct    = 42;
    quiet      = 1'b0;
    while (sent < RAND_ITEMS) begin
      if (sent == next_phase) begin
        r = $urandom_range(0, 2);
        ins_pct = (r == 0) ? 78 : (r == 1) ? 25 : 42;
        quiet = ($urandom_range(0, 3) == 0);
        next_phase += 40;
      end
      if (sent == next_drain) begin
        start <= 1'b0;
        do @(negedge clk); while (rsp_due_q.size() != 0);
        next_drain += 70;
      end
      r = $urandom_range(0, 99);
      if (r < 4) req.op = OP_NONE;
      else if (r < 16) req.op = OP_LIST;
      else if (r < 16 + ins_pct) req.op = OP_INSERT;
      else req.op = OP_DELETE;
      req.value = 8'($urandom_range(0, 255));
      issue(req, 1'b0, mk_rsp(ST_DONE, 8'h00, 1'b1), quiet ? 0 : rand_gap());
      if (req.op != OP_NONE) sent++;
    end

    start <= 1'b0;
    while (rsp_due_q.size() != 0) @(negedge clk);
    repeat (SLOTS + 8) @(negedge clk);
    if (err_cnt == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
